// File: sv/alp_pkg.sv
// ----------------------------------------------------------------------------
// alp_pkg
// Shared types and codes for the address lease pool.
// ----------------------------------------------------------------------------
package alp_pkg;

  // Request actions
  typedef enum logic [1:0] {
    ACT_ASSIGN  = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_SWEEP   = 2'd2,
    ACT_SWEEP_X = 2'd3
  } action_e;

  // Result status codes
  typedef enum logic [2:0] {
    STAT_ASSIGNED  = 3'd0,
    STAT_EXHAUSTED = 3'd1,
    STAT_RELEASED  = 3'd2,
    STAT_NOT_FOUND = 3'd3,
    STAT_SWEPT     = 3'd4
  } status_e;

  // Register indexes (byte address = 4 * index)
  localparam int unsigned RegIdxW = 2;
  typedef enum logic [RegIdxW-1:0] {
    REG_POOL_BASE  = 2'd0,
    REG_POOL_COUNT = 2'd1,
    REG_LEASE_LEN  = 2'd2,
    REG_NONE       = 2'd3
  } reg_idx_e;

  localparam int unsigned AddrW       = 4;
  localparam int unsigned CountW      = 9;
  localparam logic [31:0] BaseReset   = 32'd0;
  localparam logic [8:0]  CountReset  = 9'd256;
  localparam logic [31:0] LeaseReset  = 32'd3600;

  // Engine states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ASSIGN,
    ST_SWEEP
  } state_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] release_address;
    logic [31:0] now_seconds;
  } req_t;

  typedef struct packed {
    logic [31:0] granted_address;
    logic [2:0]  status;
  } res_t;

  // Configuration seen by the engine
  typedef struct packed {
    logic [31:0]       pool_base;
    logic [CountW-1:0] pool_count;
    logic [31:0]       lease_secs;
  } cfg_t;

  // One pool entry as stored in the lease memory
  typedef struct packed {
    logic        in_use;
    logic [31:0] stamp;
  } entry_t;

endpackage

// File: sv/alp_regs.sv
// ----------------------------------------------------------------------------
// alp_regs
// APB register file: pool base, pool count and lease time.
// ----------------------------------------------------------------------------
module alp_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [alp_pkg::AddrW-1:0]  paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output alp_pkg::cfg_t              cfg_o
);

  alp_pkg::cfg_t cfg_q, cfg_d;
  alp_pkg::reg_idx_e idx;
  logic wr_en;

  assign idx    = alp_pkg::reg_idx_e'(paddr[alp_pkg::AddrW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // Write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        alp_pkg::REG_POOL_BASE:  cfg_d.pool_base  = pwdata;
        alp_pkg::REG_POOL_COUNT: cfg_d.pool_count = pwdata[alp_pkg::CountW-1:0];
        alp_pkg::REG_LEASE_LEN:  cfg_d.lease_secs = pwdata;
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (idx)
      alp_pkg::REG_POOL_BASE:  prdata = cfg_q.pool_base;
      alp_pkg::REG_POOL_COUNT: prdata = 32'(cfg_q.pool_count);
      alp_pkg::REG_LEASE_LEN:  prdata = cfg_q.lease_secs;
      default:                 prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pool_base  <= alp_pkg::BaseReset;
      cfg_q.pool_count <= alp_pkg::CountReset;
      cfg_q.lease_secs <= alp_pkg::LeaseReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// File: sv/alp_engine.sv
// ----------------------------------------------------------------------------
// alp_engine
// Lease memory and the sequencer that scans, assigns, releases and sweeps.
// ----------------------------------------------------------------------------
module alp_engine #(
  parameter int unsigned POOL_DEPTH = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  alp_pkg::cfg_t cfg_i,
  input  logic          start,
  output logic          busy,
  input  alp_pkg::req_t req_i,
  output logic          res_valid_o,
  output alp_pkg::res_t res_o
);

  localparam int unsigned IdxW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int unsigned NW   = $clog2(POOL_DEPTH + 1);

  // Lease memory, one read and one write port, registered read
  alp_pkg::entry_t mem [POOL_DEPTH];
  alp_pkg::entry_t rd_q;
  logic            we, re;
  logic [IdxW-1:0] wa, ra;
  alp_pkg::entry_t wd;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_q <= mem[ra];
    end
  end

  alp_pkg::state_e state_q, state_d;
  logic [NW-1:0]   idx_q, idx_d;
  logic            pend_q, pend_d;
  logic [IdxW-1:0] pidx_q, pidx_d;
  logic [IdxW-1:0] clr_q, clr_d;
  logic [31:0]     now_q, now_d;
  logic            res_valid_q, res_valid_d;
  alp_pkg::res_t   res_q, res_d;

  logic [NW-1:0]   n_live;
  logic [31:0]     offset;
  logic            found;
  logic            accept;
  logic            expired;

  // Effective pool size: min(pool_count, depth)
  assign n_live = (32'(cfg_i.pool_count) > 32'(POOL_DEPTH)) ? NW'(POOL_DEPTH)
                                                             : NW'(cfg_i.pool_count);
  assign offset  = req_i.release_address - cfg_i.pool_base;
  assign found   = offset < 32'(n_live);
  assign accept  = start && !busy;
  assign expired = rd_q.in_use && ((now_q - rd_q.stamp) >= cfg_i.lease_secs);

  assign busy        = (state_q != alp_pkg::ST_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    pend_d      = 1'b0;
    pidx_d      = pidx_q;
    clr_d       = clr_q;
    now_d       = now_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    we          = 1'b0;
    wa          = pidx_q;
    wd          = '{in_use: 1'b0, stamp: now_q};
    re          = 1'b0;
    ra          = idx_q[IdxW-1:0];

    case (state_q)
      // Clearing pass: entry 0 (gateway) in use, the rest free
      alp_pkg::ST_CLEAR: begin
        we    = 1'b1;
        wa    = clr_q;
        wd    = '{in_use: (clr_q == '0), stamp: 32'd0};
        clr_d = clr_q + IdxW'(1);
        if (clr_q == IdxW'(POOL_DEPTH - 1)) begin
          state_d = alp_pkg::ST_IDLE;
        end
      end

      alp_pkg::ST_IDLE: begin
        if (accept) begin
          now_d = req_i.now_seconds;
          res_d.granted_address = 32'd0;
          if (req_i.action[1]) begin
            if (n_live <= NW'(1)) begin
              res_valid_d  = 1'b1;
              res_d.status = alp_pkg::STAT_SWEPT;
            end else begin
              idx_d   = NW'(1);
              state_d = alp_pkg::ST_SWEEP;
            end
          end else if (req_i.action[0]) begin
            res_valid_d = 1'b1;
            if (found) begin
              we           = 1'b1;
              wa           = offset[IdxW-1:0];
              wd           = '{in_use: 1'b0, stamp: req_i.now_seconds};
              res_d.status = alp_pkg::STAT_RELEASED;
            end else begin
              res_d.status = alp_pkg::STAT_NOT_FOUND;
            end
          end else begin
            if (n_live == '0) begin
              res_valid_d  = 1'b1;
              res_d.status = alp_pkg::STAT_EXHAUSTED;
            end else begin
              idx_d   = '0;
              state_d = alp_pkg::ST_ASSIGN;
            end
          end
        end
      end

      // Lowest-free search: read one entry a cycle, check it the next
      alp_pkg::ST_ASSIGN: begin
        if (pend_q && !rd_q.in_use) begin
          we                    = 1'b1;
          wd                    = '{in_use: 1'b1, stamp: now_q};
          res_valid_d           = 1'b1;
          res_d.granted_address = cfg_i.pool_base + 32'(pidx_q);
          res_d.status          = alp_pkg::STAT_ASSIGNED;
          state_d               = alp_pkg::ST_IDLE;
        end else if (idx_q < n_live) begin
          re     = 1'b1;
          pend_d = 1'b1;
          pidx_d = idx_q[IdxW-1:0];
          idx_d  = idx_q + NW'(1);
        end else if (pend_q) begin
          res_valid_d  = 1'b1;
          res_d.status = alp_pkg::STAT_EXHAUSTED;
          state_d      = alp_pkg::ST_IDLE;
        end
      end

      // Expiry sweep: read entry i while entry i-1, if expired, is written back as free
      alp_pkg::ST_SWEEP: begin
        if (pend_q && expired) begin
          we = 1'b1;
          wd = '{in_use: 1'b0, stamp: rd_q.stamp};
        end
        if (idx_q < n_live) begin
          re     = 1'b1;
          pend_d = 1'b1;
          pidx_d = idx_q[IdxW-1:0];
          idx_d  = idx_q + NW'(1);
        end else if (pend_q) begin
          res_valid_d  = 1'b1;
          res_d.status = alp_pkg::STAT_SWEPT;
          state_d      = alp_pkg::ST_IDLE;
        end
      end

      default: state_d = alp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= alp_pkg::ST_CLEAR;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      clr_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      clr_q       <= clr_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pidx_q <= pidx_d;
    now_q  <= now_d;
    res_q  <= res_d;
  end

  // No read and write of the same entry in one cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we && re) |-> (wa != ra))
    else $error("lease memory read and write collide");

  // Scan index stays within the live pool
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == alp_pkg::ST_ASSIGN || state_q == alp_pkg::ST_SWEEP) |-> (idx_q <= n_live))
    else $error("scan index past live pool");

  // A pending read only exists while scanning
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (state_q == alp_pkg::ST_ASSIGN || state_q == alp_pkg::ST_SWEEP))
    else $error("pending read outside a scan");

  // Only a successful assign carries an address
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.status != alp_pkg::STAT_ASSIGNED) |-> (res_q.granted_address == '0))
    else $error("address returned without an assign");

endmodule

// File: sv/address_lease_pool.sv
// ----------------------------------------------------------------------------
// address_lease_pool
// Pool of consecutive addresses with lease tracking, APB configured.
// ----------------------------------------------------------------------------
// Release: result strobe in the cycle after the request. Assign: entries are read from
// index 0 up, each checked once its read returns; the lowest free one of the n live entries
// is granted, else exhausted. Sweep: one lease memory read per entry 1 to n-1.
// One request at a time; busy drops in the cycle the result strobe rises.
// After reset a clearing pass over all POOL_DEPTH entries holds busy high.
// Results are strobed for one cycle; the receiver cannot stall.
module address_lease_pool #(
  parameter int unsigned POOL_DEPTH = 256
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  alp_pkg::req_t             req_i,
  output logic                      res_valid_o,
  output alp_pkg::res_t             res_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [alp_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  alp_pkg::cfg_t cfg;

  // Configuration registers
  alp_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Lease memory and sequencer
  alp_engine #(
    .POOL_DEPTH (POOL_DEPTH)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule
